// ----- rtl/tcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track centerline steering package
// Shared constants, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int IMG_WIDTH_DEF = 320;
  localparam int IMG_ROWS_DEF  = 128;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [15:0] CENTER_DUTY_RST = 16'd4455;
  localparam logic [15:0] DUTY_MIN_RST    = 16'd3960;
  localparam logic [15:0] DUTY_MAX_RST    = 16'd4950;
  localparam logic [6:0]  VIEW_TOP_RST    = 7'd40;
  localparam logic [6:0]  VIEW_BOTTOM_RST = 7'd90;
  localparam int          PREV_DEV_RST    = 160;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_DUTY = 3'd0,
    CFG_PROP_GAIN   = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_DUTY_MIN    = 3'd3,
    CFG_DUTY_MAX    = 3'd4,
    CFG_VIEW_TOP    = 3'd5,
    CFG_VIEW_BOTTOM = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]        center_duty;
    logic signed [10:0] prop_gain;
    logic signed [10:0] deriv_gain;
    logic [15:0]        duty_min;
    logic [15:0]        duty_max;
    logic [6:0]         view_top;
    logic [6:0]         view_bottom;
  } cfg_t;

endpackage

// ----- rtl/tcs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tcs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame loader
// Places incoming words into the frame memory and flags a completed frame.
// ----------------------------------------------------------------------------
module tcs_front #(
  parameter int FRAME_BYTES = 5120
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     pixels,
  input  logic                           frame_start,
  output logic                           wr_en,
  output logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output logic                           frame_done
);

  localparam int AW = $clog2(FRAME_BYTES);

  logic [AW-1:0] pos;
  logic [AW-1:0] cur;
  logic          last;

  assign cur        = frame_start ? '0 : pos;
  assign last       = (cur == AW'(FRAME_BYTES - 1));
  assign wr_en      = accept;
  assign wr_addr    = cur;
  assign wr_data    = pixels;
  assign frame_done = accept && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= last ? '0 : cur + AW'(1);
    end
  end

endmodule

// ----- rtl/tcs_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centerline scanner
// Walks the frame from the bottom row up, one memory word per step, and
// records the free span's midpoint per row until a row's center is set.
// ----------------------------------------------------------------------------
module tcs_scan
  import tcs_pkg::*;
#(
  parameter int IMG_WIDTH = IMG_WIDTH_DEF,
  parameter int IMG_ROWS  = IMG_ROWS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               start,
  output logic                                               busy,
  output logic [$clog2(((IMG_WIDTH+7)/8)*IMG_ROWS)-1:0]      rd_addr,
  input  logic [7:0]                                         rd_data,
  output logic                                               mid_we,
  output logic [$clog2(IMG_ROWS)-1:0]                        mid_addr,
  output logic [$clog2(IMG_WIDTH)-1:0]                       mid_data,
  output logic                                               done,
  output logic [$clog2(IMG_ROWS)-1:0]                        reached_row
);

  localparam int RB       = (IMG_WIDTH + 7) / 8;
  localparam int FB       = RB * IMG_ROWS;
  localparam int FAW      = $clog2(FB);
  localparam int CW       = $clog2(IMG_WIDTH);
  localparam int BW       = $clog2(RB);
  localparam int RW       = $clog2(IMG_ROWS);
  localparam int LAST_OFF = (IMG_WIDTH - 1) % 8;
  localparam int C0       = (IMG_WIDTH - 1) / 2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EVAL = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    PH_CENTER = 3'b001,
    PH_RIGHT  = 3'b010,
    PH_LEFT   = 3'b100
  } phase_t;

  state_t        state;
  phase_t        phase;
  logic [RW-1:0] row;
  logic [FAW-1:0] base;
  logic [CW-1:0] center;
  logic [BW-1:0] byte_i;
  logic [CW-1:0] right;

  logic [BW-1:0] cbyte;
  logic [2:0]    coff;
  logic          at_cbyte;
  logic          at_last;
  logic [2:0]    r_lo;
  logic [2:0]    r_hi;
  logic [2:0]    l_hi;
  logic [2:0]    r_off;
  logic [2:0]    l_off;
  logic          r_found;
  logic          l_found;
  logic          left_end;
  logic [CW-1:0] left_v;
  logic [CW:0]   lr_sum;
  logic [CW-1:0] newc;

  assign cbyte    = BW'(center[CW-1:3]);
  assign coff     = center[2:0];
  assign at_cbyte = (byte_i == cbyte);
  assign at_last  = (byte_i == BW'(RB - 1));
  assign rd_addr  = base + FAW'(byte_i);
  assign busy     = (state != S_IDLE);

  always_comb begin
    r_lo    = at_cbyte ? coff : 3'd0;
    r_hi    = at_last ? 3'(LAST_OFF) : 3'd7;
    l_hi    = at_cbyte ? coff : 3'd7;
    r_found = 1'b0;
    r_off   = 3'd0;
    l_found = 1'b0;
    l_off   = 3'd0;
    for (int o = 7; o >= 0; o--) begin
      if (3'(o) >= r_lo && 3'(o) <= r_hi && rd_data[7-o]) begin
        r_found = 1'b1;
        r_off   = 3'(o);
      end
    end
    for (int o = 0; o < 8; o++) begin
      if (3'(o) <= l_hi && rd_data[7-o]) begin
        l_found = 1'b1;
        l_off   = 3'(o);
      end
    end
  end

  assign left_end = l_found || (byte_i == '0);
  assign left_v   = l_found ? CW'({byte_i, l_off}) + CW'(1) : '0;
  assign lr_sum   = {1'b0, left_v} + {1'b0, right};
  assign newc     = lr_sum[CW:1];

  assign mid_we   = (state == S_EVAL) && (phase == PH_LEFT) && left_end;
  assign mid_addr = row;
  assign mid_data = newc;

  always_comb begin
    done = 1'b0;
    if (state == S_EVAL) begin
      case (phase)
        PH_CENTER: done = rd_data[3'd7 - coff];
        PH_LEFT:   done = left_end && (row == '0);
        default:   done = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_CENTER;
      reached_row <= RW'(IMG_ROWS - 1);
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            row    <= RW'(IMG_ROWS - 1);
            base   <= FAW'((IMG_ROWS - 1) * RB);
            center <= CW'(C0);
            byte_i <= BW'(C0 / 8);
            phase  <= PH_CENTER;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_READ;
          case (phase)
            PH_CENTER: begin
              if (rd_data[3'd7 - coff]) begin
                state <= S_IDLE;
              end else begin
                phase <= PH_RIGHT;
              end
            end
            PH_RIGHT: begin
              if (r_found) begin
                right  <= CW'({byte_i, r_off}) - CW'(1);
                phase  <= PH_LEFT;
                byte_i <= cbyte;
              end else if (at_last) begin
                right  <= CW'(IMG_WIDTH - 1);
                phase  <= PH_LEFT;
                byte_i <= cbyte;
              end else begin
                byte_i <= byte_i + BW'(1);
              end
            end
            PH_LEFT: begin
              if (left_end) begin
                reached_row <= row;
                center      <= newc;
                if (row == '0) begin
                  state <= S_IDLE;
                end else begin
                  row    <= row - RW'(1);
                  base   <= base - FAW'(RB);
                  byte_i <= BW'(newc[CW-1:3]);
                  phase  <= PH_CENTER;
                end
              end else begin
                byte_i <= byte_i - BW'(1);
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/tcs_steer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Steering law
// Averages the midline offset over the view window with a serial divider
// and turns it into a clamped PD servo duty.
// ----------------------------------------------------------------------------
module tcs_steer
  import tcs_pkg::*;
#(
  parameter int IMG_WIDTH = IMG_WIDTH_DEF,
  parameter int IMG_ROWS  = IMG_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  cfg_t                         cfg,
  input  logic [$clog2(IMG_ROWS)-1:0]  reached_row,
  output logic [$clog2(IMG_ROWS)-1:0]  mid_addr,
  input  logic [$clog2(IMG_WIDTH)-1:0] mid_data,
  output logic                         busy,
  output logic                         out_valid,
  output logic [15:0]                  servo_duty,
  output logic signed [9:0]            deviation,
  output logic [6:0]                   top_row,
  output logic                         empty_window
);

  localparam int RW     = $clog2(IMG_ROWS);
  localparam int CW     = $clog2(IMG_WIDTH);
  localparam int XW     = ((RW > 7) ? RW : 7) + 1;
  localparam int DEV_W  = (CW + 2 > 10) ? CW + 2 : 10;
  localparam int CNT_W  = 8;
  localparam int SUM_W  = DEV_W + CNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int D_W    = DEV_W + 14;
  localparam int HALF   = IMG_WIDTH / 2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SETUP = 10'b0000000010,
    S_READ  = 10'b0000000100,
    S_ACC   = 10'b0000001000,
    S_DSET  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_DFIN  = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_ADD   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t                    state;
  logic [XW-1:0]             deadline;
  logic [XW-1:0]             row_i;
  logic                      weight2;
  logic                      empty;
  logic [CNT_W-1:0]          cnt;
  logic signed [SUM_W-1:0]   sum;
  logic                      neg;
  logic [SUM_W-1:0]          dq;
  logic [CNT_W-1:0]          rem;
  logic [STEP_W-1:0]         dstep;
  logic signed [DEV_W-1:0]   dev;
  logic signed [DEV_W-1:0]   prev;
  logic signed [DEV_W+10:0]  p1;
  logic signed [DEV_W+11:0]  p2;
  logic signed [D_W-1:0]     duty_s;

  logic [XW-1:0]             reached_x;
  logic [XW-1:0]             top_x;
  logic [XW-1:0]             bottom_x;
  logic [XW-1:0]             dl_c;
  logic [CW-1:0]             mid_v;
  logic signed [CW+1:0]      term;
  logic signed [CW+1:0]      wterm;
  logic [CNT_W:0]            trial;
  logic                      ge;
  logic signed [DEV_W:0]     dd;
  logic signed [D_W-1:0]     dmax;
  logic signed [D_W-1:0]     dmin;
  logic signed [D_W-1:0]     dclamp;

  assign reached_x = XW'(reached_row);
  assign top_x     = XW'(cfg.view_top);
  assign bottom_x  = XW'(cfg.view_bottom);
  assign dl_c      = (reached_x > top_x) ? reached_x : top_x;
  assign mid_addr  = row_i[RW-1:0];
  assign busy      = (state != S_IDLE);

  assign mid_v = (row_i < XW'(IMG_ROWS)) ? mid_data : '0;
  assign term  = $signed({2'b00, mid_v}) - $signed((CW+2)'(HALF));
  assign wterm = weight2 ? (term <<< 1) : term;

  assign trial = {rem, dq[SUM_W-1]};
  assign ge    = (trial >= {1'b0, cnt});

  assign dd     = (DEV_W+1)'(dev) - (DEV_W+1)'(prev);
  assign dmax   = $signed(D_W'({1'b0, cfg.duty_max}));
  assign dmin   = $signed(D_W'({1'b0, cfg.duty_min}));

  always_comb begin
    dclamp = (duty_s > dmax) ? dmax : duty_s;
    if (dclamp < dmin) begin
      dclamp = dmin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      prev      <= DEV_W'(PREV_DEV_RST);
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          deadline <= dl_c;
          weight2  <= (dl_c == bottom_x);
          empty    <= (dl_c > bottom_x);
          row_i    <= bottom_x;
          cnt      <= '0;
          sum      <= '0;
          dev      <= '0;
          state    <= (dl_c > bottom_x) ? S_MUL : S_READ;
        end
        S_READ: begin
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum + SUM_W'(wterm);
          cnt <= cnt + CNT_W'(1);
          if (row_i == deadline) begin
            state <= S_DSET;
          end else begin
            row_i <= row_i - XW'(1);
            state <= S_READ;
          end
        end
        S_DSET: begin
          neg   <= sum[SUM_W-1];
          dq    <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
          rem   <= '0;
          dstep <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= ge ? CNT_W'(trial - {1'b0, cnt}) : CNT_W'(trial);
          dq    <= {dq[SUM_W-2:0], ge};
          dstep <= dstep + STEP_W'(1);
          if (dstep == STEP_W'(SUM_W - 1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          dev   <= neg ? -DEV_W'(dq) : DEV_W'(dq);
          state <= S_MUL;
        end
        S_MUL: begin
          p1    <= dev * cfg.prop_gain;
          p2    <= dd * cfg.deriv_gain;
          state <= S_ADD;
        end
        S_ADD: begin
          duty_s <= $signed(D_W'({1'b0, cfg.center_duty})) + D_W'(p1) + D_W'(p2);
          state  <= S_OUT;
        end
        S_OUT: begin
          servo_duty   <= dclamp[15:0];
          deviation    <= dev[9:0];
          top_row      <= 7'(reached_row);
          empty_window <= empty;
          prev         <= dev;
          out_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/track_centerline_steering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track centerline steering
// Loads a one-bit frame word by word, scans the track centerline and
// produces a clamped PD servo duty once per completed frame.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while a frame loads; busy is high from the
// last word of a frame until its result has been presented.
// Work: each scanned row reads the center word, then the words searched
// right and left over the single frame memory read port; then the window
// rows are read and summed, 20 divider steps run and the duty is formed.
// Each result is shown for one cycle on done; the receiver cannot stall.
// Reset is synchronous: position, scan state and registers take their
// defaults; the frame and midline memories are not cleared.
// ----------------------------------------------------------------------------
module track_centerline_steering
  import tcs_pkg::*;
#(
  parameter int IMG_WIDTH = IMG_WIDTH_DEF,
  parameter int IMG_ROWS  = IMG_ROWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            pixels,
  input  logic                  frame_start,
  output logic                  done,
  output logic [15:0]           servo_duty,
  output logic signed [9:0]     deviation,
  output logic [6:0]            top_row,
  output logic                  empty_window,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RB  = (IMG_WIDTH + 7) / 8;
  localparam int FB  = RB * IMG_ROWS;
  localparam int FAW = $clog2(FB);
  localparam int CW  = $clog2(IMG_WIDTH);
  localparam int RW  = $clog2(IMG_ROWS);

  cfg_t           cfg;
  logic           accept;
  logic           wr_en;
  logic [FAW-1:0] wr_addr;
  logic [7:0]     wr_data;
  logic           frame_done;
  logic           pending;
  logic           scan_start;
  logic           scan_busy;
  logic           scan_done;
  logic [FAW-1:0] rd_addr;
  logic [7:0]     rd_data;
  logic           mid_we;
  logic [RW-1:0]  mid_waddr;
  logic [CW-1:0]  mid_wdata;
  logic [RW-1:0]  mid_raddr;
  logic [CW-1:0]  mid_rdata;
  logic [RW-1:0]  reached_row;
  logic           steer_busy;

  assign cfg_ready  = 1'b1;
  assign busy       = pending || scan_busy || steer_busy;
  assign accept     = start && !busy;
  assign scan_start = pending && !scan_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_duty <= CENTER_DUTY_RST;
      cfg.prop_gain   <= '0;
      cfg.deriv_gain  <= '0;
      cfg.duty_min    <= DUTY_MIN_RST;
      cfg.duty_max    <= DUTY_MAX_RST;
      cfg.view_top    <= VIEW_TOP_RST;
      cfg.view_bottom <= VIEW_BOTTOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_DUTY: cfg.center_duty <= cfg_data;
        CFG_PROP_GAIN:   cfg.prop_gain   <= cfg_data[10:0];
        CFG_DERIV_GAIN:  cfg.deriv_gain  <= cfg_data[10:0];
        CFG_DUTY_MIN:    cfg.duty_min    <= cfg_data;
        CFG_DUTY_MAX:    cfg.duty_max    <= cfg_data;
        CFG_VIEW_TOP:    cfg.view_top    <= cfg_data[6:0];
        CFG_VIEW_BOTTOM: cfg.view_bottom <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (frame_done) begin
      pending <= 1'b1;
    end else if (scan_start) begin
      pending <= 1'b0;
    end
  end

  tcs_front #(
    .FRAME_BYTES(FB)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixels     (pixels),
    .frame_start(frame_start),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .frame_done (frame_done)
  );

  tcs_ram #(
    .WIDTH(8),
    .DEPTH(FB)
  ) u_frame_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  tcs_scan #(
    .IMG_WIDTH(IMG_WIDTH),
    .IMG_ROWS (IMG_ROWS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .busy       (scan_busy),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .mid_we     (mid_we),
    .mid_addr   (mid_waddr),
    .mid_data   (mid_wdata),
    .done       (scan_done),
    .reached_row(reached_row)
  );

  tcs_ram #(
    .WIDTH(CW),
    .DEPTH(IMG_ROWS)
  ) u_mid_ram (
    .clk  (clk),
    .we   (mid_we),
    .waddr(mid_waddr),
    .wdata(mid_wdata),
    .raddr(mid_raddr),
    .rdata(mid_rdata)
  );

  tcs_steer #(
    .IMG_WIDTH(IMG_WIDTH),
    .IMG_ROWS (IMG_ROWS)
  ) u_steer (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_done),
    .cfg         (cfg),
    .reached_row (reached_row),
    .mid_addr    (mid_raddr),
    .mid_data    (mid_rdata),
    .busy        (steer_busy),
    .out_valid   (done),
    .servo_duty  (servo_duty),
    .deviation   (deviation),
    .top_row     (top_row),
    .empty_window(empty_window)
  );

endmodule
